### hw/rtl/decimal_long_multiplier_defines.svh
// ----------------------------------------------------------------------------
// Decimal long multiplier assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_LONG_MULTIPLIER_DEFINES_SVH
`define DECIMAL_LONG_MULTIPLIER_DEFINES_SVH

// Condition implies a consequence in the same cycle.
`define DLM_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition implies a consequence in the following cycle.
`define DLM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/dlm_pkg.sv
// ----------------------------------------------------------------------------
// Decimal long multiplier package
// Types and constants shared by the decimal long multiplier.
// ----------------------------------------------------------------------------
package dlm_pkg;

    // Default digit capacity of each operand.
    localparam int MAX_DIGITS_DEF = 32;

    // Width of one decimal digit and its largest value.
    localparam int DIGIT_W = 4;
    localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

    // Column sum width; holds 32 products of 81 plus an incoming carry.
    localparam int COL_W = 12;

    // Carry register width and the widened value seen during carry propagation.
    localparam int CARRY_W = 10;
    localparam int VAL_W   = COL_W + 1;

    // Divide by ten through a reciprocal: floor(v * 3277 / 2^15) for v below 16384.
    localparam int DIV10_MUL_W = 12;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 12'd3277;
    localparam int DIV10_SHIFT = 15;
    localparam logic [3:0] RADIX = 4'd10;

    // Operand select codes.
    localparam logic OP_FIRST  = 1'b0;
    localparam logic OP_SECOND = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MAC,
        ST_MAC_END,
        ST_CARRY,
        ST_CARRY_END,
        ST_EMIT_RD,
        ST_EMIT_WR
    } dlm_state_t;

    // Kind of column write held in the write-back stage.
    typedef enum logic {
        KIND_MAC,
        KIND_CARRY
    } dlm_kind_t;

endpackage

### hw/rtl/decimal_long_multiplier.sv
// ----------------------------------------------------------------------------
// Decimal long multiplier
// Schoolbook multiplication of two decimal numbers held digit by digit.
// ----------------------------------------------------------------------------
// Input channel (digit_valid / digit_stall): one transfer per decimal digit,
// most significant first. operation selects the operand; last_digit on a
// digit of the second operand starts the multiply. Digits past MAX_DIGITS are
// dropped and reported through too_long. Loading takes one digit per cycle
// while idle. Output channel (result_valid / result_stall): one transfer per
// product digit, most significant first, with a zero top digit skipped;
// final_res marks the least significant digit.
// With la and lb digits and T = la + lb, a multiply clears the T columns,
// accumulates the la*lb digit products (one digit product per cycle through
// the column memory), runs a carry pass and emits, skipping the accumulate
// step for an empty first operand. The multiply-accumulate loop over the
// column sum memory sets the run time for long operands; the input is stalled
// meanwhile. When the receiver stalls, the result register holds and the
// emitter waits. Reset empties both operands and the result register; the
// digit memories need no clearing, the column memory is cleared per multiply.
// ----------------------------------------------------------------------------
`include "decimal_long_multiplier_defines.svh"

module decimal_long_multiplier #(
    parameter int MAX_DIGITS = dlm_pkg::MAX_DIGITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        digit_valid,
    output logic                        digit_stall,
    input  logic                        operation,
    input  logic [dlm_pkg::DIGIT_W-1:0] digit,
    input  logic                        last_digit,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [dlm_pkg::DIGIT_W-1:0] product_digit,
    output logic                        group_mark,
    output logic                        final_res,
    output logic                        too_long
);
    import dlm_pkg::*;

    localparam int AW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int LEN_W  = $clog2(MAX_DIGITS + 1);
    localparam int CDEPTH = 2 * MAX_DIGITS;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int TOT_W  = $clog2(CDEPTH + 1);

    // Memories
    logic [DIGIT_W-1:0] first_mem  [MAX_DIGITS];
    logic [DIGIT_W-1:0] second_mem [MAX_DIGITS];
    logic [COL_W-1:0]   col_mem    [CDEPTH];

    // State and counters
    dlm_state_t         state_reg, state_next;
    logic [LEN_W-1:0]   first_len_reg, first_len_next;
    logic [LEN_W-1:0]   second_len_reg, second_len_next;
    logic               overflow_reg, overflow_next;
    logic [LEN_W-1:0]   la_reg, la_next;
    logic [LEN_W-1:0]   lb_reg, lb_next;
    logic               too_long_reg, too_long_next;
    logic [LEN_W-1:0]   i_reg, i_next;
    logic [LEN_W-1:0]   j_reg, j_next;
    logic [TOT_W-1:0]   pos_reg, pos_next;
    logic [1:0]         mod3_reg, mod3_next;
    logic [CARRY_W-1:0] carry_reg, carry_next;

    // Write-back stage and forwarding
    logic               s2_valid_reg, s2_valid_next;
    dlm_kind_t          s2_kind_reg, s2_kind_next;
    logic [CAW-1:0]     s2_addr_reg;
    logic               fwd_reg, fwd_next;
    logic [COL_W-1:0]   fwd_data_reg;

    // Memory read data
    logic [DIGIT_W-1:0] a_rdata_reg;
    logic [DIGIT_W-1:0] b_rdata_reg;
    logic [COL_W-1:0]   col_rdata_reg;

    // Result register
    logic               result_valid_reg, result_valid_next;
    logic [DIGIT_W-1:0] product_digit_reg;
    logic               group_mark_reg;
    logic               final_res_reg;
    logic               too_long_out_reg;

    // Combinational signals
    logic               digit_xfer;
    logic               first_room;
    logic               second_room;
    logic               first_we;
    logic               second_we;
    logic               trigger;
    logic [DIGIT_W-1:0] digit_sat;
    logic [TOT_W-1:0]   total;
    logic [TOT_W-1:0]   last_pos;
    logic [LEN_W-1:0]   la_m1;
    logic [LEN_W-1:0]   lb_m1;
    logic               j_end;
    logic               mac_last;
    logic               pos_end;
    logic [CAW-1:0]     mac_addr;
    logic [AW-1:0]      a_addr;
    logic [AW-1:0]      b_addr;
    logic               ab_re;
    logic               col_re;
    logic [CAW-1:0]     col_raddr;
    logic               col_we;
    logic [CAW-1:0]     col_waddr;
    logic [COL_W-1:0]   col_wdata;
    logic [COL_W-1:0]   col_eff;
    logic [VAL_W-1:0]   mac_sum;
    logic [VAL_W-1:0]   carry_val;
    logic [VAL_W+DIV10_MUL_W-1:0] div_prod;
    logic [CARRY_W-1:0] carry_q;
    logic [VAL_W-1:0]   carry_rem;
    logic               out_free;
    logic               emit_top_zero;
    logic               emit_step;
    logic               emit_load;

    // Input decode
    assign digit_stall = (state_reg != ST_IDLE);
    assign digit_xfer  = digit_valid && !digit_stall;
    assign first_room  = (first_len_reg < LEN_W'(MAX_DIGITS));
    assign second_room = (second_len_reg < LEN_W'(MAX_DIGITS));
    assign first_we    = digit_xfer && (operation == OP_FIRST) && first_room;
    assign second_we   = digit_xfer && (operation == OP_SECOND) && second_room;
    assign trigger     = digit_xfer && (operation == OP_SECOND) && last_digit;
    assign digit_sat   = (digit > MAX_DIGIT) ? MAX_DIGIT : digit;

    // Loop bounds
    assign total    = TOT_W'(la_reg) + TOT_W'(lb_reg);
    assign last_pos = total - TOT_W'(1);
    assign la_m1    = la_reg - LEN_W'(1);
    assign lb_m1    = lb_reg - LEN_W'(1);
    assign j_end    = (j_reg == lb_m1);
    assign mac_last = j_end && (i_reg == la_m1);
    assign pos_end  = (pos_reg == last_pos);

    // Digit product addressing, least significant digits first
    assign mac_addr = CAW'(i_reg) + CAW'(j_reg);
    assign a_addr   = AW'(la_m1 - i_reg);
    assign b_addr   = AW'(lb_m1 - j_reg);

    // Multiply-accumulate write-back with forwarding of the previous write
    assign col_eff = fwd_reg ? fwd_data_reg : col_rdata_reg;
    assign mac_sum = VAL_W'(col_eff) + VAL_W'(a_rdata_reg) * VAL_W'(b_rdata_reg);

    // Carry propagation: split column value into digit and carry
    assign carry_val = VAL_W'(col_rdata_reg) + VAL_W'(carry_reg);
    assign div_prod  = carry_val * DIV10_MUL;
    assign carry_q   = div_prod[DIV10_SHIFT +: CARRY_W];
    assign carry_rem = carry_val - VAL_W'(carry_q) * VAL_W'(RADIX);

    // Emit control
    assign out_free      = !result_valid_reg || !result_stall;
    assign emit_top_zero = (pos_reg == last_pos) && (col_rdata_reg == '0);
    assign emit_step     = (state_reg == ST_EMIT_WR) && (emit_top_zero || out_free);
    assign emit_load     = (state_reg == ST_EMIT_WR) && !emit_top_zero && out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (trigger)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (pos_end)
                begin
                    state_next = (la_reg == '0) ? ST_CARRY : ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (mac_last)
                begin
                    state_next = ST_MAC_END;
                end
            end
            ST_MAC_END:
            begin
                state_next = ST_CARRY;
            end
            ST_CARRY:
            begin
                if (pos_end)
                begin
                    state_next = ST_CARRY_END;
                end
            end
            ST_CARRY_END:
            begin
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (emit_step)
                begin
                    state_next = (pos_reg == '0) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory port control per state
    always_comb
    begin
        ab_re         = 1'b0;
        col_re        = 1'b0;
        col_raddr     = mac_addr;
        s2_valid_next = 1'b0;
        s2_kind_next  = KIND_MAC;
        unique case (state_reg)
            ST_MAC:
            begin
                ab_re         = 1'b1;
                col_re        = 1'b1;
                col_raddr     = mac_addr;
                s2_valid_next = 1'b1;
                s2_kind_next  = KIND_MAC;
            end
            ST_CARRY:
            begin
                col_re        = 1'b1;
                col_raddr     = pos_reg[CAW-1:0];
                s2_valid_next = 1'b1;
                s2_kind_next  = KIND_CARRY;
            end
            ST_EMIT_RD:
            begin
                col_re    = 1'b1;
                col_raddr = pos_reg[CAW-1:0];
            end
            default:
            begin
                col_re = 1'b0;
            end
        endcase

        // Column writes: clearing pass or write-back stage
        if (state_reg == ST_CLEAR)
        begin
            col_we    = 1'b1;
            col_waddr = pos_reg[CAW-1:0];
            col_wdata = '0;
        end
        else
        begin
            col_we    = s2_valid_reg;
            col_waddr = s2_addr_reg;
            col_wdata = (s2_kind_reg == KIND_MAC) ? mac_sum[COL_W-1:0]
                                                  : carry_rem[COL_W-1:0];
        end

        // Same column read while it is being written: take the written value
        fwd_next = (state_reg == ST_MAC) && s2_valid_reg && (s2_addr_reg == mac_addr);
    end

    // Counter and operand bookkeeping
    always_comb
    begin
        first_len_next    = first_len_reg;
        second_len_next   = second_len_reg;
        overflow_next     = overflow_reg;
        la_next           = la_reg;
        lb_next           = lb_reg;
        too_long_next     = too_long_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        pos_next          = pos_reg;
        mod3_next         = mod3_reg;
        carry_next        = carry_reg;
        result_valid_next = result_valid_reg && result_stall;

        // Operand loading
        if (first_we)
        begin
            first_len_next = first_len_reg + LEN_W'(1);
        end
        if (second_we)
        begin
            second_len_next = second_len_reg + LEN_W'(1);
        end
        if (digit_xfer && ((operation == OP_FIRST) ? !first_room : !second_room))
        begin
            overflow_next = 1'b1;
        end

        // Multiply start: latch lengths and begin a fresh pair
        if (trigger)
        begin
            la_next         = first_len_reg;
            lb_next         = second_len_next;
            too_long_next   = overflow_next;
            first_len_next  = '0;
            second_len_next = '0;
            overflow_next   = 1'b0;
            i_next          = '0;
            j_next          = '0;
            pos_next        = '0;
            mod3_next       = '0;
            carry_next      = '0;
        end

        // Clearing pass
        if (state_reg == ST_CLEAR)
        begin
            pos_next = pos_end ? '0 : pos_reg + TOT_W'(1);
        end

        // Digit product loop
        if (state_reg == ST_MAC)
        begin
            if (j_end)
            begin
                j_next = '0;
                i_next = i_reg + LEN_W'(1);
            end
            else
            begin
                j_next = j_reg + LEN_W'(1);
            end
        end

        // Carry pass walks up and tracks the position modulo three
        if (state_reg == ST_CARRY && !pos_end)
        begin
            pos_next  = pos_reg + TOT_W'(1);
            mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
        end
        if (s2_valid_reg && s2_kind_reg == KIND_CARRY)
        begin
            carry_next = carry_q;
        end

        // Emission walks down
        if (emit_step)
        begin
            pos_next  = pos_reg - TOT_W'(1);
            mod3_next = (mod3_reg == 2'd0) ? 2'd2 : mod3_reg - 2'd1;
        end
        if (emit_load)
        begin
            result_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_len_reg    <= '0;
            second_len_reg   <= '0;
            overflow_reg     <= 1'b0;
            la_reg           <= '0;
            lb_reg           <= '0;
            too_long_reg     <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            pos_reg          <= '0;
            mod3_reg         <= '0;
            carry_reg        <= '0;
            s2_valid_reg     <= 1'b0;
            s2_kind_reg      <= KIND_MAC;
            fwd_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_len_reg    <= first_len_next;
            second_len_reg   <= second_len_next;
            overflow_reg     <= overflow_next;
            la_reg           <= la_next;
            lb_reg           <= lb_next;
            too_long_reg     <= too_long_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            pos_reg          <= pos_next;
            mod3_reg         <= mod3_next;
            carry_reg        <= carry_next;
            s2_valid_reg     <= s2_valid_next;
            s2_kind_reg      <= s2_kind_next;
            fwd_reg          <= fwd_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Write-back stage payload
    always_ff @(posedge clk)
    begin
        s2_addr_reg  <= col_raddr;
        fwd_data_reg <= col_wdata;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            product_digit_reg <= col_rdata_reg[DIGIT_W-1:0];
            group_mark_reg    <= (pos_reg != '0) && (mod3_reg == 2'd0);
            final_res_reg     <= (pos_reg == '0);
            too_long_out_reg  <= too_long_reg;
        end
    end

    // First operand memory
    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[first_len_reg[AW-1:0]] <= digit_sat;
        end
        if (ab_re)
        begin
            a_rdata_reg <= first_mem[a_addr];
        end
    end

    // Second operand memory
    always_ff @(posedge clk)
    begin
        if (second_we)
        begin
            second_mem[second_len_reg[AW-1:0]] <= digit_sat;
        end
        if (ab_re)
        begin
            b_rdata_reg <= second_mem[b_addr];
        end
    end

    // Column sum memory
    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_waddr] <= col_wdata;
        end
        if (col_re)
        begin
            col_rdata_reg <= col_mem[col_raddr];
        end
    end

    // Outputs
    assign result_valid  = result_valid_reg;
    assign product_digit = product_digit_reg;
    assign group_mark    = group_mark_reg;
    assign final_res     = final_res_reg;
    assign too_long      = too_long_out_reg;

    // Checks
    `DLM_ASSERT_IMPLY(a_mac_range, state_reg == ST_MAC,
        (i_reg < la_reg) && (j_reg < lb_reg), "digit product index out of range")
    `DLM_ASSERT_IMPLY(a_fwd_mac, fwd_reg,
        s2_valid_reg && (s2_kind_reg == KIND_MAC), "forward outside accumulate")
    `DLM_ASSERT_IMPLY(a_col_fits, s2_valid_reg && (s2_kind_reg == KIND_MAC),
        !mac_sum[COL_W], "column sum overflow")
    `DLM_ASSERT_IMPLY(a_carry_digit, s2_valid_reg && (s2_kind_reg == KIND_CARRY),
        carry_rem < VAL_W'(RADIX), "carry remainder not a digit")
    `DLM_ASSERT_NEXT(a_mac_drained, state_reg == ST_MAC_END,
        !s2_valid_reg, "write-back busy at carry start")

endmodule
